// ----- src/q4dq_pkg.sv -----
// ---------------------------------------------------------------------------
// q4dq_pkg
// Shared types and constants for the 4-bit dequantising dot product.
// ---------------------------------------------------------------------------
package q4dq_pkg;

  // field widths
  localparam int unsigned CodeW       = 4;
  localparam int unsigned PackedW     = 2 * CodeW;
  localparam int unsigned EntryW      = 16;
  localparam int unsigned ScaleW      = 16;
  localparam int unsigned WeightW     = EntryW + ScaleW + 1;
  localparam int unsigned SumW        = 64;
  localparam int unsigned ActWidthDef = 16;

  // configuration port
  localparam int unsigned NumTableRegs  = 4;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 64;
  localparam int unsigned EntriesPerReg = CfgDataW / EntryW;
  localparam int unsigned RegSelW       = $clog2(NumTableRegs);
  localparam int unsigned EntrySelW     = $clog2(EntriesPerReg);

  localparam logic [CodeW-1:0] NibbleMask = 4'h0F;

  // code table held in the configuration registers
  typedef logic [NumTableRegs-1:0][CfgDataW-1:0] table_t;

  // per-stage control carried alongside the lanes
  typedef struct packed {
    logic valid;
    logic last;
  } ctrl_t;

  // stage enables handed to each lane
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

endpackage

// ----- src/q4dq_lane.sv -----
// ---------------------------------------------------------------------------
// q4dq_lane
// One dequantise-and-multiply lane: table lookup times scale, then times
// the activation, one register after each multiplication.
// ---------------------------------------------------------------------------
module q4dq_lane #(
  parameter int unsigned ActWidth = q4dq_pkg::ActWidthDef
) (
  input  logic                                        clk_i,
  input  q4dq_pkg::stage_en_t                         en_i,
  input  q4dq_pkg::table_t                            table_i,
  input  logic [q4dq_pkg::CodeW-1:0]                  code_i,
  input  logic [q4dq_pkg::ScaleW-1:0]                 scale_i,
  input  logic signed [ActWidth-1:0]                  act_i,
  output logic signed [q4dq_pkg::WeightW+ActWidth-1:0] prod_o
);
  import q4dq_pkg::*;

  localparam int unsigned ProdW = WeightW + ActWidth;

  logic [CfgDataW-1:0]       sel_reg;
  logic [EntrySelW-1:0]      entry_sel;
  logic signed [EntryW-1:0]  entry;
  logic signed [ScaleW:0]    scale_s;
  logic signed [WeightW-1:0] weight_d, weight_q;
  logic signed [ActWidth-1:0] act_q;
  logic signed [ProdW-1:0]   prod_d, prod_q;

  // table lookup: upper code bits pick the register, lower bits the entry
  always_comb begin
    sel_reg   = table_i[code_i[CodeW-1 -: RegSelW]];
    entry_sel = code_i[EntrySelW-1:0];
    entry     = sel_reg[EntryW*entry_sel +: EntryW];
    scale_s   = {1'b0, scale_i};
    weight_d  = WeightW'(entry) * WeightW'(scale_s);
  end

  // stage 1: dequantised weight
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      weight_q <= weight_d;
      act_q    <= act_i;
    end
  end

  assign prod_d = ProdW'(weight_q) * ProdW'(act_q);

  // stage 2: weight times activation
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- src/q4dq_merge.sv -----
// ---------------------------------------------------------------------------
// q4dq_merge
// Merging stage: adds the two lane products, accumulates with 64-bit
// saturation and holds the finished row sum for the output channel.
// ---------------------------------------------------------------------------
module q4dq_merge #(
  parameter int unsigned ActWidth = q4dq_pkg::ActWidthDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         adv_i,
  input  q4dq_pkg::ctrl_t                              ctrl_i,
  input  logic signed [q4dq_pkg::WeightW+ActWidth-1:0] prod_a_i,
  input  logic signed [q4dq_pkg::WeightW+ActWidth-1:0] prod_b_i,
  output logic                                         out_valid_o,
  output logic signed [q4dq_pkg::SumW-1:0]             sum_o
);
  import q4dq_pkg::*;

  localparam int unsigned ProdW = WeightW + ActWidth;
  localparam int unsigned TermW = ProdW + 1;
  localparam int unsigned ExtW  = ((TermW > SumW) ? TermW : SumW) + 1;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  logic signed [TermW-1:0] term;
  logic signed [ExtW-1:0]  sum_ext;
  logic [ExtW-SumW:0]      sum_top;
  logic                    fits;
  logic signed [SumW-1:0]  sum_sat;
  logic signed [SumW-1:0]  acc_d, acc_q;
  logic signed [SumW-1:0]  out_d, out_q;
  logic                    out_valid_d, out_valid_q;

  // exact pair sum, then saturating accumulate
  always_comb begin
    term    = TermW'(prod_a_i) + TermW'(prod_b_i);
    sum_ext = ExtW'(acc_q) + ExtW'(term);
    sum_top = sum_ext[ExtW-1:SumW-1];
    fits    = (&sum_top) | ~(|sum_top);
    if (fits) begin
      sum_sat = sum_ext[SumW-1:0];
    end else if (sum_ext[ExtW-1]) begin
      sum_sat = SumMin;
    end else begin
      sum_sat = SumMax;
    end
  end

  // next accumulator and output register values
  always_comb begin
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (adv_i) begin
      out_valid_d = ctrl_i.valid & ctrl_i.last;
      if (ctrl_i.valid) begin
        if (ctrl_i.last) begin
          out_d = sum_sat;
          acc_d = '0;
        end else begin
          acc_d = sum_sat;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign sum_o       = out_q;

endmodule

// ----- src/quant4_dequant_dot_product_top.sv -----
// ---------------------------------------------------------------------------
// quant4_dequant_dot_product_top
// One output row of an activation vector times a 4-bit quantised weight
// matrix, with a 16-entry code table held in configuration registers.
// ---------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid_i / in_ready_o   packed_codes_i, act_first_i, act_second_i,
//                                     block_scale_i, last_of_row_i
//  out      out_valid_o / out_ready_i dot_sum_o
//  cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  One request is taken per cycle while the pipeline advances; out_valid_o rises
//  once the request marked last has passed the weight register of each lane,
//  which loads on the edge that takes it, then the product register and the
//  merging output register. While a result waits unread the whole pipeline
//  holds, so in_ready_o drops. Reset clears the accumulator, the code table
//  and all valid flags. Configuration writes are always taken.
// ---------------------------------------------------------------------------
module quant4_dequant_dot_product_top #(
  parameter int unsigned ActWidth = q4dq_pkg::ActWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [q4dq_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [q4dq_pkg::CfgDataW-1:0]        cfg_data_i,
  // input requests
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [q4dq_pkg::PackedW-1:0]         packed_codes_i,
  input  logic signed [ActWidth-1:0]           act_first_i,
  input  logic signed [ActWidth-1:0]           act_second_i,
  input  logic [q4dq_pkg::ScaleW-1:0]          block_scale_i,
  input  logic                                 last_of_row_i,
  // results
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [q4dq_pkg::SumW-1:0]     dot_sum_o
);
  import q4dq_pkg::*;

  localparam int unsigned ProdW = WeightW + ActWidth;

  table_t                  table_q;
  ctrl_t                   s1_d, s1_q, s2_q;
  stage_en_t               lane_en;
  logic                    adv;
  logic [CodeW-1:0]        code_hi, code_lo;
  logic signed [ProdW-1:0] prod_hi, prod_lo;

  // configuration writes, out-of-range indexes ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i < CfgIdxW'(NumTableRegs))) begin
      table_q[cfg_index_i[RegSelW-1:0]] <= cfg_data_i;
    end
  end

  // pipeline advances unless a result is stuck in the output register
  assign adv        = ~(out_valid_o & ~out_ready_i);
  assign in_ready_o = adv;

  assign s1_d.valid = in_valid_i;
  assign s1_d.last  = last_of_row_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (adv) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
    end
  end

  assign lane_en.s1 = adv & in_valid_i;
  assign lane_en.s2 = adv & s1_q.valid;

  // split the packed byte: high nibble pairs with the first activation
  assign code_hi = CodeW'(packed_codes_i >> CodeW) & NibbleMask;
  assign code_lo = packed_codes_i[CodeW-1:0] & NibbleMask;

  // two lanes, one per code
  q4dq_lane #(
    .ActWidth (ActWidth)
  ) u_lane_hi (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .table_i (table_q),
    .code_i  (code_hi),
    .scale_i (block_scale_i),
    .act_i   (act_first_i),
    .prod_o  (prod_hi)
  );

  q4dq_lane #(
    .ActWidth (ActWidth)
  ) u_lane_lo (
    .clk_i   (clk_i),
    .en_i    (lane_en),
    .table_i (table_q),
    .code_i  (code_lo),
    .scale_i (block_scale_i),
    .act_i   (act_second_i),
    .prod_o  (prod_lo)
  );

  // merge, accumulate and hold the result
  q4dq_merge #(
    .ActWidth (ActWidth)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctrl_i      (s2_q),
    .prod_a_i    (prod_hi),
    .prod_b_i    (prod_lo),
    .out_valid_o (out_valid_o),
    .sum_o       (dot_sum_o)
  );

endmodule

// ----- tb/sv/tb_quant4_dequant_dot_product_top.sv -----
// ---------------------------------------------------------------------------
// tb_quant4_dequant_dot_product_top
// Self-checking bench for the 4-bit dequantising row dot product. Requests
// carry packed code pairs, activations and a block scale. A scoreboard
// rebuilds every row sum, with saturation, from its own copy of the code
// table and compares each result in order. Directed rows cover the field
// extremes and every code. Random phases then run under several table
// settings, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_quant4_dequant_dot_product_top;
  import q4dq_pkg::*;

  localparam int unsigned ActW        = ActWidthDef;
  localparam int unsigned MaxIdle     = 13;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned PhaseItems  = 185;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] TableReg0     = 3'd0;
  localparam logic [CfgIdxW-1:0] SpareRegFirst = 3'd4;
  localparam logic [CfgIdxW-1:0] SpareRegLast  = 3'd7;

  // table setting of each random phase
  typedef enum int unsigned {
    TblZero, TblRandom, TblMostNeg, TblMostPos, TblRandomAgain, TblAllOnes
  } table_kind_e;

  // -------------------------------------------------------------------------
  // scoreboard: own copy of the table and the running row sum
  // -------------------------------------------------------------------------
  class row_sum_board;
    localparam longint SumMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SumMin = -SumMax - 1;

    table_t      code_table;
    longint      row_acc;
    longint      pending_sums[$];
    int unsigned fail_count;

    function new();
      code_table = '0;
      row_acc    = 0;
      fail_count = 0;
    endfunction

    function void set_table(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx < CfgIdxW'(NumTableRegs)) code_table[idx[RegSelW-1:0]] = data;
    endfunction

    function longint weight_of(logic [3:0] code, logic [ScaleW-1:0] scale);
      logic [EntryW-1:0] raw;
      longint            entry;
      longint            scl;
      raw   = code_table[code[3:2]][EntryW*code[1:0] +: EntryW];
      entry = longint'($signed(raw));
      scl   = scale;
      return entry * scl;
    endfunction

    // fold one accepted request into the row sum
    function void add_weight_pair(logic [PackedW-1:0] codes,
                                  logic signed [ActW-1:0] act_a,
                                  logic signed [ActW-1:0] act_b,
                                  logic [ScaleW-1:0] scale, logic last);
      longint              term;
      longint              av;
      longint              bv;
      logic signed [SumW:0] wide;
      av   = act_a;
      bv   = act_b;
      term = weight_of(codes[7:4], scale) * av + weight_of(codes[3:0], scale) * bv;
      wide = row_acc;
      wide = wide + term;
      if (wide > SumMax) row_acc = SumMax;
      else if (wide < SumMin) row_acc = SumMin;
      else row_acc = longint'(wide);
      if (last) begin
        pending_sums.push_back(row_acc);
        row_acc = 0;
      end
    endfunction

    // compare one returned row sum with the oldest prediction
    function void check_row_sum(logic signed [SumW-1:0] got);
      longint want;
      if (pending_sums.size() == 0) begin
        $display("%0t unexpected dot_sum: expected none, actual %0d", $time, got);
        fail_count++;
      end else begin
        want = pending_sums.pop_front();
        if (got !== want) begin
          $display("%0t dot_sum mismatch: expected %0d, actual %0d", $time, want, got);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i;
  logic [CfgDataW-1:0]      cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [PackedW-1:0]       packed_codes_i;
  logic signed [ActW-1:0]   act_first_i;
  logic signed [ActW-1:0]   act_second_i;
  logic [ScaleW-1:0]        block_scale_i;
  logic                     last_of_row_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [SumW-1:0]   dot_sum_o;

  row_sum_board board;
  bit           send_idle_en;
  bit           recv_stall_en;

  quant4_dequant_dot_product_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .packed_codes_i (packed_codes_i),
    .act_first_i    (act_first_i),
    .act_second_i   (act_second_i),
    .block_scale_i  (block_scale_i),
    .last_of_row_i  (last_of_row_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dot_sum_o      (dot_sum_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // note every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      board.add_weight_pair(packed_codes_i, act_first_i, act_second_i,
                            block_scale_i, last_of_row_i);
    end
  end

  // check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_row_sum(dot_sum_o);
  end

  // result side: random stalls, redrawn stretches without any
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    forever begin
      if (taken % 8 == 0) recv_stall_en = ($urandom_range(0, 3) != 0);
      stall = recv_stall_en ? $urandom_range(0, MaxIdle) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  // one input request, after an optional random gap
  task automatic send_request(input logic [PackedW-1:0] codes,
                              input logic signed [ActW-1:0] act_a,
                              input logic signed [ActW-1:0] act_b,
                              input logic [ScaleW-1:0] scale, input logic last,
                              input bit allow_gap);
    int unsigned gap;
    gap = (allow_gap && send_idle_en) ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    packed_codes_i <= codes;
    act_first_i    <= act_a;
    act_second_i   <= act_b;
    block_scale_i  <= scale;
    last_of_row_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold off until every row sum is back and the pipeline has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (board.pending_sums.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write all four table registers and one spare index, which is ignored
  task automatic program_table(input table_t tbl);
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    for (int i = 0; i <= NumTableRegs; i++) begin
      if (i < NumTableRegs) begin
        idx  = TableReg0 + CfgIdxW'(i);
        data = tbl[i];
      end else begin
        idx  = CfgIdxW'($urandom_range(SpareRegFirst, SpareRegLast));
        data = {$urandom, $urandom};
      end
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      board.set_table(idx, data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [ActW-1:0] draw_act();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      default: return ActW'($urandom);
    endcase
  endfunction

  function automatic logic [ScaleW-1:0] draw_scale();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'hFFFF;
      2: return 16'h0100;
      default: return ScaleW'($urandom);
    endcase
  endfunction

  // main sequence
  initial begin : stimulus
    table_t      tbl;
    table_kind_e kind;
    int unsigned row_odds;
    logic [3:0]  nib;

    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    packed_codes_i = '0;
    act_first_i    = '0;
    act_second_i   = '0;
    block_scale_i  = '0;
    last_of_row_i  = 1'b0;
    out_ready_i    = 1'b0;
    send_idle_en   = 1'b1;
    board          = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: zero, one, both limits, all-ones and mixed patterns
    tbl[0] = 64'h7FFF_8000_0001_0000;
    tbl[1] = 64'h1234_C000_4000_FFFF;
    tbl[2] = 64'h0100_FF00_5555_AAAA;
    tbl[3] = 64'h8001_7FFE_0F0F_F0F0;
    program_table(tbl);

    // every code in both nibbles, rows of four
    for (int i = 0; i < 16; i++) begin
      nib = CodeW'(i);
      send_request({nib, ~nib}, (i % 2) ? 16'sh8000 : 16'sh7FFF,
                   (i % 3 == 0) ? 16'sh8000 : 16'sh3039,
                   (i % 4 == 0) ? 16'hFFFF : ScaleW'(i * 4099), (i % 4 == 3), 1'b1);
    end
    // all-zero row, largest positive single terms, high/low pairing
    send_request(8'h00, '0, '0, '0, 1'b1, 1'b1);
    send_request(8'h22, 16'sh8000, 16'sh8000, 16'hFFFF, 1'b1, 1'b1);
    send_request(8'h23, 16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b1, 1'b1);
    send_request(8'h31, 16'sh0002, 16'sh0005, 16'h0100, 1'b0, 1'b1);
    send_request(8'h13, 16'sh0002, 16'sh0005, 16'h0100, 1'b1, 1'b1);
    send_request(8'hFF, 16'sh7FFF, 16'sh8000, 16'h0001, 1'b1, 1'b1);
    drain();

    // random phases, one table setting each
    for (int p = TblZero; p <= TblAllOnes; p++) begin
      kind = table_kind_e'(p);
      for (int r = 0; r < NumTableRegs; r++) begin
        case (kind)
          TblZero:    tbl[r] = '0;
          TblMostNeg: tbl[r] = {4{16'h8000}};
          TblMostPos: tbl[r] = {4{16'h7FFF}};
          TblAllOnes: tbl[r] = '1;
          default:    tbl[r] = {$urandom, $urandom};
        endcase
      end
      program_table(tbl);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 50 == 0) begin
          send_idle_en = ($urandom_range(0, 3) != 0);
          row_odds     = $urandom_range(1, 12);
        end
        // pause mid-phase until every row sum has come back
        if (kind == TblMostNeg && n == PhaseItems / 2) drain();
        send_request(PackedW'($urandom), draw_act(), draw_act(), draw_scale(),
                     ($urandom_range(1, row_odds) == 1), 1'b1);
      end
      // close the row so that nothing is left in the accumulator
      send_request(PackedW'($urandom), draw_act(), draw_act(), draw_scale(), 1'b1, 1'b1);
      drain();
    end

    if (board.fail_count == 0 && board.pending_sums.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/q4dq_pkg.sv
src/q4dq_lane.sv
src/q4dq_merge.sv
src/quant4_dequant_dot_product_top.sv
tb/sv/tb_quant4_dequant_dot_product_top.sv
